// ===== design/fifo_queue_with_queries_core_macros.svh =====
// Assertion macros shared by the design files.
`ifndef FIFO_QUEUE_WITH_QUERIES_CORE_MACROS_SVH
`define FIFO_QUEUE_WITH_QUERIES_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FQQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FQQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FQQ_ASSERT(label, clk, rst_n, prop, msg)
`define FQQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== design/fqq_pkg.sv =====
`default_nettype none
package fqq_pkg;
  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_DUMP  = 3'd1,
    ACT_POP   = 3'd2,
    ACT_CLEAR = 3'd3,
    ACT_MEAN  = 3'd4,
    ACT_EVENS = 3'd5,
    ACT_COUNT = 3'd6,
    ACT_RDUMP = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ACK     = 3'd3,
    ST_NO_EVEN = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DIV,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;      // capture the request
    logic    push;
    logic    pop;
    logic    clear;
    logic    rd_first;  // issue the read of the first walked entry
    logic    walk;      // consume read data and step
    logic    div_start;
    logic    div_step;
    logic    emit;      // drive one result from the datapath
    logic    emit_last;
    logic    emit_fixed;  // drive a fixed status with zero value
    status_e fixed_status;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic walk_last;   // the entry now consumed is the final one
    logic walk_hit;    // the consumed entry is to be listed
    logic any_hit;     // at least one even entry found so far
    logic pend;        // an earlier even entry waits in the hold register
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

// ===== design/fqq_ctrl.sv =====
`default_nettype none
module fqq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic [2:0]    action_i,
  input  wire fqq_pkg::stat_t stat_i,
  output fqq_pkg::ctrl_t     ctrl_o,
  output logic               busy
);
  import fqq_pkg::*;
  `include "fifo_queue_with_queries_core_macros.svh"

  state_e  state_q, state_d;
  action_e act_q, act_d;
  action_e act_in;

  assign act_in = action_e'(action_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= ACT_PUSH;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
    end
  end

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    ctrl_o  = '0;
    busy    = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (start) begin
          act_d = act_in;
          ctrl_o.load = 1'b1;
          ctrl_o.fixed_status = ST_ACK;
          case (act_in)
            ACT_PUSH: begin
              ctrl_o.emit_fixed = 1'b1;
              ctrl_o.emit_last  = 1'b1;
              if (stat_i.full) begin
                ctrl_o.fixed_status = ST_FULL;
              end else begin
                ctrl_o.push = 1'b1;
              end
            end
            ACT_CLEAR: begin
              ctrl_o.clear      = 1'b1;
              ctrl_o.emit_fixed = 1'b1;
              ctrl_o.emit_last  = 1'b1;
            end
            ACT_COUNT, ACT_EVENS: begin
              if (stat_i.empty) begin
                ctrl_o.emit_fixed = 1'b1;
                ctrl_o.emit_last  = 1'b1;
                ctrl_o.fixed_status = (act_in == ACT_COUNT) ? ST_DATA : ST_NO_EVEN;
              end else begin
                ctrl_o.rd_first = 1'b1;
                state_d = S_WALK;
              end
            end
            default: begin
              if (stat_i.empty) begin
                ctrl_o.emit_fixed = 1'b1;
                ctrl_o.emit_last  = 1'b1;
                ctrl_o.fixed_status = ST_EMPTY;
              end else begin
                ctrl_o.rd_first = 1'b1;
                state_d = S_WALK;
              end
            end
          endcase
        end
      end
      S_WALK: begin
        ctrl_o.walk = 1'b1;
        case (act_q)
          ACT_POP: begin
            ctrl_o.pop = 1'b1;
            ctrl_o.emit = 1'b1;
            ctrl_o.emit_last = 1'b1;
            state_d = S_IDLE;
          end
          ACT_DUMP, ACT_RDUMP: begin
            ctrl_o.emit = 1'b1;
            ctrl_o.emit_last = stat_i.walk_last;
            if (stat_i.walk_last) state_d = S_IDLE;
          end
          ACT_EVENS: begin
            // A new hit releases the previous one, which is known not to be last.
            ctrl_o.emit = stat_i.walk_hit & stat_i.pend;
            if (stat_i.walk_last) begin
              if (stat_i.any_hit) begin
                state_d = S_DONE;
              end else begin
                ctrl_o.emit_fixed = 1'b1;
                ctrl_o.emit_last = 1'b1;
                ctrl_o.fixed_status = ST_NO_EVEN;
                state_d = S_IDLE;
              end
            end
          end
          ACT_COUNT: begin
            if (stat_i.walk_last) state_d = S_DONE;
          end
          default: begin
            if (stat_i.walk_last) begin
              ctrl_o.div_start = 1'b1;
              state_d = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = S_DONE;
      end
      S_DONE: begin
        // Final result of a count, a mean, or the held last even entry.
        ctrl_o.emit = 1'b1;
        ctrl_o.emit_last = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  `FQQ_ASSERT(a_load_idle, clk_i, rst_ni, ctrl_o.load |-> !busy, "load while busy")
  `FQQ_ASSERT(a_div_state, clk_i, rst_ni, ctrl_o.div_step |-> (act_q == ACT_MEAN), "div off mean")
  `FQQ_ASSERT(a_emit_excl, clk_i, rst_ni, !(ctrl_o.emit && ctrl_o.emit_fixed), "two emits")
endmodule
`default_nettype wire

// ===== design/fqq_dp.sv =====
`default_nettype none
module fqq_dp #(
  parameter int unsigned Depth = fqq_pkg::DefaultDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [2:0]     action_i,
  input  wire logic signed [31:0] operand_i,
  input  wire fqq_pkg::ctrl_t ctrl_i,
  output fqq_pkg::stat_t      stat_o,
  output logic                result_strobe_o,
  output logic signed [39:0]  result_value_o,
  output logic [2:0]          status_o,
  output logic                last_o
);
  import fqq_pkg::*;
  `include "fifo_queue_with_queries_core_macros.svh"

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned SumW = 32 + CntW + 8;   // sum times 256
  localparam int unsigned DivCycles = SumW;

  logic [31:0] mem_q [Depth];
  logic [31:0] rd_q;

  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] left_q, left_d;
  logic            rev_q;
  logic [31:0]     key_q;
  logic [2:0]      action_q;
  logic [31:0]     held_q;
  logic signed [SumW-1:0] acc_q, acc_d;
  logic            any_q, any_d;
  logic [$clog2(DivCycles+1)-1:0] dcnt_q;
  logic [SumW-1:0] quo_q, rem_mag_q;
  logic            neg_q;
  logic [SumW:0]   trial;

  logic            out_v_q, out_last_q;
  logic signed [39:0] out_val_q;
  logic [2:0]      out_st_q;

  logic [IdxW-1:0] rd_addr;
  logic [31:0]     cur;
  logic            hit;

  function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] i);
    return (i == IdxW'(Depth - 1)) ? '0 : i + 1'b1;
  endfunction
  function automatic logic [IdxW-1:0] prv(input logic [IdxW-1:0] i);
    return (i == '0) ? IdxW'(Depth - 1) : i - 1'b1;
  endfunction

  assign cur = rd_q;
  assign hit = (action_e'(action_q) == ACT_EVENS) ? !cur[0] : 1'b0;

  // Pointer stepped per cycle; the read address leads the consumed entry.
  always_comb begin
    rd_addr = ptr_q;
    if (ctrl_i.rd_first) begin
      rd_addr = (action_e'(action_i) == ACT_RDUMP) ? prv(tail_q) : head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) mem_q[tail_q] <= operand_i;
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    left_d  = left_q;
    acc_d   = acc_q;
    any_d   = any_q;
    if (ctrl_i.push) begin
      tail_d  = nxt(tail_q);
      count_d = count_q + 1'b1;
    end
    if (ctrl_i.pop) begin
      head_d  = nxt(head_q);
      count_d = count_q - 1'b1;
      if (count_q == CntW'(1)) begin
        head_d = '0;
        tail_d = '0;
      end
    end
    if (ctrl_i.clear) begin
      head_d = '0; tail_d = '0; count_d = '0;
    end
    if (ctrl_i.rd_first) begin
      ptr_d  = (action_e'(action_i) == ACT_RDUMP) ? prv(prv(tail_q)) : nxt(head_q);
      left_d = count_q;
      acc_d  = '0;
      any_d  = 1'b0;
    end else if (ctrl_i.walk) begin
      ptr_d  = rev_q ? prv(ptr_q) : nxt(ptr_q);
      left_d = left_q - 1'b1;
      any_d  = any_q | hit;
      case (action_e'(action_q))
        ACT_COUNT: acc_d = acc_q + SumW'(cur == key_q);
        default:   acc_d = acc_q + SumW'($signed(cur));
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; tail_q <= '0; count_q <= '0;
      out_v_q <= 1'b0; out_last_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      head_q <= head_d; tail_q <= tail_d; count_q <= count_d;
      out_v_q <= ctrl_i.emit | ctrl_i.emit_fixed;
      out_last_q <= ctrl_i.emit_last;
      if (ctrl_i.div_start) dcnt_q <= ($clog2(DivCycles+1))'(DivCycles);
      else if (ctrl_i.div_step && dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
    end
  end

  // Restoring divider on magnitudes, one quotient bit per cycle.
  assign trial = {rem_mag_q, quo_q[SumW-1]} - {{(SumW+1-CntW){1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    left_q <= left_d;
    any_q  <= any_d;
    if (ctrl_i.load) begin
      action_q <= action_i;
      key_q    <= operand_i;
      rev_q    <= (action_e'(action_i) == ACT_RDUMP);
    end
    // Even entries are shown one hit late, so the final one can carry last.
    if (ctrl_i.walk && hit) held_q <= cur;
    if (ctrl_i.div_start) begin
      acc_q <= acc_d <<< 8;
    end else begin
      acc_q <= acc_d;
    end
    if (ctrl_i.div_start) begin
      neg_q     <= acc_d[SumW-1];
      rem_mag_q <= '0;
      quo_q     <= acc_d[SumW-1] ? SumW'(-(acc_d <<< 8)) : SumW'(acc_d <<< 8);
    end else if (ctrl_i.div_step && dcnt_q != '0) begin
      if (!trial[SumW]) begin
        rem_mag_q <= trial[SumW-1:0];
        quo_q     <= {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_mag_q <= {rem_mag_q[SumW-2:0], quo_q[SumW-1]};
        quo_q     <= {quo_q[SumW-2:0], 1'b0};
      end
    end
    if (ctrl_i.emit_fixed) begin
      out_val_q <= '0;
      out_st_q  <= ctrl_i.fixed_status;
    end else if (ctrl_i.emit) begin
      out_st_q <= ST_DATA;
      if (action_e'(action_q) == ACT_EVENS) out_val_q <= 40'($signed(held_q));
      else if (ctrl_i.walk) out_val_q <= 40'($signed(cur));
      else if (action_e'(action_q) == ACT_MEAN)
        out_val_q <= neg_q ? -40'(quo_q) : 40'(quo_q);
      else if (action_e'(action_q) == ACT_COUNT) out_val_q <= 40'(acc_q);
    end
  end

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CntW'(Depth));
  assign stat_o.walk_last = (left_q == CntW'(1));
  assign stat_o.walk_hit  = hit;
  assign stat_o.any_hit   = any_q | hit;
  assign stat_o.pend      = any_q;
  assign stat_o.div_done  = (dcnt_q == '0);

  assign result_strobe_o = out_v_q;
  assign result_value_o  = out_val_q;
  assign status_o        = out_st_q;
  assign last_o          = out_last_q;

  `FQQ_ASSERT(a_cnt_range, clk_i, rst_ni, count_q <= CntW'(Depth), "count over depth")
  `FQQ_ASSERT(a_empty_ptrs, clk_i, rst_ni, (count_q == '0) |-> (head_q == '0 && tail_q == '0), "ptrs")
  `FQQ_ASSERT(a_no_pushfull, clk_i, rst_ni, ctrl_i.push |-> !stat_o.full, "push on full")
endmodule
`default_nettype wire

// ===== design/fifo_queue_with_queries_core.sv =====
`default_nettype none
// FIFO of signed 32-bit words with query requests, one request per start.
// Push, clear and the empty or full cases emit their result word straight from the idle state;
// pop and dumps read the entry first, and dumps then give one word per cycle.
// A new request can be taken while the last word of the previous one shows. The mean
// request runs a restoring divider over SumW = 40+clog2(DEPTH+1) bits after its walk.
// Results cannot be stalled. Reset (rst_ni low, asynchronous) empties the queue; words stay.
module fifo_queue_with_queries_core #(
  parameter int unsigned DEPTH = fqq_pkg::DefaultDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         action_i,
  input  wire logic signed [31:0] operand_i,
  output logic                    result_strobe_o,
  output logic signed [39:0]      result_value_o,
  output logic [2:0]              status_o,
  output logic                    last_o
);
  import fqq_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  ctl_busy;

  // The result register shows each controller emit in the cycle after it. busy also covers
  // any word shown without last; it is low while the final word is shown,
  // so the next request can be taken in that cycle.
  assign busy = ctl_busy | (result_strobe_o & !last_o);

  fqq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start & !busy),
    .action_i (action_i),
    .stat_i   (stat),
    .ctrl_o   (ctrl),
    .busy     (ctl_busy)
  );

  fqq_dp #(.Depth(DEPTH)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .action_i        (action_i),
    .operand_i       (operand_i),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .result_strobe_o (result_strobe_o),
    .result_value_o  (result_value_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );
endmodule
`default_nettype wire
